@@ src/gpr_pkg.sv @@
// Shared types, register offsets and field constants for the GPIO register block.
`timescale 1ns / 1ps
package gpr_pkg;

    localparam int PIN_COUNT_DEF  = 58;
    localparam int PIN_COUNT_MAX  = 64;
    localparam int BUS_WIDTH      = 32;
    localparam int OFS_WIDTH      = 6;
    localparam int FSEL_WIDTH     = 3;
    localparam int PINS_PER_FSEL  = 10;
    localparam int FSEL_BITS      = FSEL_WIDTH * PINS_PER_FSEL;
    localparam int PULL_WIDTH     = 2;
    localparam int PINS_PER_PULL  = 16;
    localparam int PULL_WORDS     = 4;

    typedef logic [OFS_WIDTH-1:0] ofs_t;

    localparam ofs_t OFS_SET0    = 6'd7;
    localparam ofs_t OFS_CLR0    = 6'd10;
    localparam ofs_t OFS_LEV0    = 6'd13;
    localparam ofs_t OFS_PUD     = 6'd37;
    localparam ofs_t OFS_PUDCLK0 = 6'd38;
    localparam ofs_t OFS_PULL0   = 6'd57;

    localparam logic [FSEL_WIDTH-1:0] FSEL_OUTPUT = 3'd1;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_t;

    typedef enum logic {
        SCHEME_LEGACY = 1'b0,
        SCHEME_FIELD  = 1'b1
    } scheme_t;

    typedef enum logic [PULL_WIDTH-1:0] {
        PULL_NONE = 2'd0,
        PULL_UP   = 2'd1,
        PULL_DOWN = 2'd2,
        PULL_OFF  = 2'd3
    } pull_t;

endpackage

@@ src/gpr_in_stage.sv @@
// Input register: holds one accepted bus access until the core takes it.
`timescale 1ns / 1ps
module gpr_in_stage #(
    parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [gpr_pkg::OFS_WIDTH-1:0]  s_reg_offset,
    input  logic [gpr_pkg::BUS_WIDTH-1:0]  s_write_data,
    input  logic [PIN_COUNT-1:0]           s_pad_levels,
    input  logic                           advance,
    output logic                           req_valid,
    output logic                           req_type,
    output logic [gpr_pkg::OFS_WIDTH-1:0]  req_offset,
    output logic [gpr_pkg::BUS_WIDTH-1:0]  req_data,
    output logic [PIN_COUNT-1:0]           req_pads
);
    import gpr_pkg::*;

    logic                  valid_reg;
    logic                  type_reg;
    logic [OFS_WIDTH-1:0]  offset_reg;
    logic [BUS_WIDTH-1:0]  data_reg;
    logic [PIN_COUNT-1:0]  pads_reg;
    logic                  take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            type_reg   <= s_req_type;
            offset_reg <= s_reg_offset;
            data_reg   <= s_write_data;
            pads_reg   <= s_pad_levels;
        end
    end

    assign req_valid  = valid_reg;
    assign req_type   = type_reg;
    assign req_offset = offset_reg;
    assign req_data   = data_reg;
    assign req_pads   = pads_reg;

endmodule

@@ src/gpr_core.sv @@
// Register file and access decode: function selects, output latch, pulls.
`timescale 1ns / 1ps
module gpr_core #(
    parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           advance,
    input  logic                           req_type,
    input  logic [gpr_pkg::OFS_WIDTH-1:0]  req_offset,
    input  logic [gpr_pkg::BUS_WIDTH-1:0]  req_data,
    input  logic [PIN_COUNT-1:0]           req_pads,
    output logic [gpr_pkg::BUS_WIDTH-1:0]  res_read_data,
    output logic [PIN_COUNT-1:0]           res_drive_levels,
    output logic [PIN_COUNT-1:0]           res_drive_enable,
    output logic [PIN_COUNT-1:0]           res_pull_up,
    output logic [PIN_COUNT-1:0]           res_pull_down
);
    import gpr_pkg::*;

    localparam int   FSEL_WORDS  = (PIN_COUNT + PINS_PER_FSEL - 1) / PINS_PER_FSEL;
    localparam int   FSEL_IDX_W  = $clog2(FSEL_WORDS);
    localparam ofs_t FSEL_LIMIT  = ofs_t'(FSEL_WORDS);
    localparam int   PULL_IDX_W  = $clog2(PULL_WORDS);

    logic [FSEL_BITS-1:0]   fsel_reg  [FSEL_WORDS];
    logic [FSEL_BITS-1:0]   fsel_next [FSEL_WORDS];
    logic [PIN_COUNT-1:0]   latch_reg, latch_next;
    logic [PULL_WIDTH-1:0]  pull_reg  [PIN_COUNT];
    logic [PULL_WIDTH-1:0]  pull_next [PIN_COUNT];
    logic [PULL_WIDTH-1:0]  lpc_reg, lpc_next;
    scheme_t                scheme_reg;

    logic                   wr;
    logic                   hi_set, hi_clr, hi_lev, hi_clk;
    logic [PIN_COUNT_MAX-1:0] data_lo64, data_hi64, lev64;
    logic [PIN_COUNT-1:0]   bits_lo, bits_hi;
    logic [PIN_COUNT-1:0]   en_cur, en_new, lev;
    logic [PULL_WIDTH-1:0]  legacy_code;
    logic [BUS_WIDTH-1:0]   pf_word [PULL_WORDS];
    logic [OFS_WIDTH-1:0]   pf_diff;
    logic [PULL_IDX_W-1:0]  pf_idx;
    logic                   pf_hit;
    logic [BUS_WIDTH-1:0]   rd;

    assign wr = (req_t'(req_type) == REQ_WRITE);

    // Data word placed into the low or high pin bank.
    always_comb begin
        data_lo64 = {{(PIN_COUNT_MAX-BUS_WIDTH){1'b0}}, req_data};
        data_hi64 = {req_data, {BUS_WIDTH{1'b0}}};
        bits_lo   = data_lo64[PIN_COUNT-1:0];
        bits_hi   = data_hi64[PIN_COUNT-1:0];
    end

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            en_cur[p] = (fsel_reg[p / PINS_PER_FSEL][(p % PINS_PER_FSEL) * FSEL_WIDTH +: FSEL_WIDTH]
                         == FSEL_OUTPUT);
            en_new[p] = (fsel_next[p / PINS_PER_FSEL][(p % PINS_PER_FSEL) * FSEL_WIDTH +: FSEL_WIDTH]
                         == FSEL_OUTPUT);
        end
    end

    always_comb begin
        lev   = (latch_reg & en_cur) | (req_pads & ~en_cur);
        lev64 = '0;
        lev64[PIN_COUNT-1:0] = lev;
    end

    // Pull field words built from the per-pin states at fixed positions.
    always_comb begin
        for (int w = 0; w < PULL_WORDS; w++) begin
            pf_word[w] = '0;
            for (int i = 0; i < PINS_PER_PULL; i++) begin
                if (w * PINS_PER_PULL + i < PIN_COUNT) begin
                    pf_word[w][i * PULL_WIDTH +: PULL_WIDTH] = pull_reg[w * PINS_PER_PULL + i];
                end
            end
        end
    end

    assign hi_set      = (req_offset == OFS_SET0 + 6'd1);
    assign hi_clr      = (req_offset == OFS_CLR0 + 6'd1);
    assign hi_lev      = (req_offset == OFS_LEV0 + 6'd1);
    assign hi_clk      = (req_offset == OFS_PUDCLK0 + 6'd1);
    // legacy coding is 2 up / 1 down; internal is 1 up / 2 down
    assign legacy_code = {lpc_reg[0], lpc_reg[1]};
    assign pf_diff     = req_offset - OFS_PULL0;
    assign pf_idx      = pf_diff[PULL_IDX_W-1:0];
    assign pf_hit      = (scheme_reg == SCHEME_FIELD) && (req_offset >= OFS_PULL0) &&
                         (req_offset < OFS_PULL0 + 6'(PULL_WORDS));

    always_comb begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        pull_next  = pull_reg;
        lpc_next   = lpc_reg;
        rd         = '0;
        if (req_offset < FSEL_LIMIT) begin
            if (wr) begin
                fsel_next[req_offset[FSEL_IDX_W-1:0]] = req_data[FSEL_BITS-1:0];
            end else begin
                rd = {{(BUS_WIDTH-FSEL_BITS){1'b0}}, fsel_reg[req_offset[FSEL_IDX_W-1:0]]};
            end
        end else if (req_offset == OFS_SET0 || hi_set) begin
            if (wr) begin
                latch_next = latch_reg | (hi_set ? bits_hi : bits_lo);
            end
        end else if (req_offset == OFS_CLR0 || hi_clr) begin
            if (wr) begin
                latch_next = latch_reg & ~(hi_clr ? bits_hi : bits_lo);
            end
        end else if (req_offset == OFS_LEV0 || hi_lev) begin
            if (!wr) begin
                rd = hi_lev ? lev64[2*BUS_WIDTH-1:BUS_WIDTH] : lev64[BUS_WIDTH-1:0];
            end
        end else if (scheme_reg == SCHEME_LEGACY && req_offset == OFS_PUD) begin
            if (wr) begin
                lpc_next = req_data[PULL_WIDTH-1:0];
            end else begin
                rd = {{(BUS_WIDTH-PULL_WIDTH){1'b0}}, lpc_reg};
            end
        end else if (scheme_reg == SCHEME_LEGACY && (req_offset == OFS_PUDCLK0 || hi_clk)) begin
            if (wr) begin
                for (int p = 0; p < PIN_COUNT; p++) begin
                    if (hi_clk ? bits_hi[p] : bits_lo[p]) begin
                        pull_next[p] = legacy_code;
                    end
                end
            end
        end else if (pf_hit) begin
            if (wr) begin
                for (int p = 0; p < PIN_COUNT; p++) begin
                    if (pf_idx == PULL_IDX_W'(p / PINS_PER_PULL)) begin
                        pull_next[p] = req_data[(p % PINS_PER_PULL) * PULL_WIDTH +: PULL_WIDTH];
                    end
                end
            end else begin
                rd = pf_word[pf_idx];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            res_pull_up[p]   = (pull_t'(pull_next[p]) == PULL_UP);
            res_pull_down[p] = (pull_t'(pull_next[p]) == PULL_DOWN);
        end
    end

    assign res_read_data    = wr ? '0 : rd;
    assign res_drive_levels = latch_next;
    assign res_drive_enable = en_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                fsel_reg[w] <= '0;
            end
            for (int p = 0; p < PIN_COUNT; p++) begin
                pull_reg[p] <= PULL_NONE;
            end
            latch_reg <= '0;
            lpc_reg   <= '0;
        end else if (advance) begin
            fsel_reg  <= fsel_next;
            pull_reg  <= pull_next;
            latch_reg <= latch_next;
            lpc_reg   <= lpc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg <= SCHEME_LEGACY;
        end else if (cfg_wr_en) begin
            scheme_reg <= scheme_t'(cfg_wr_data);
        end
    end

endmodule

@@ src/gpr_out_stage.sv @@
// Result register: holds one finished result until the consumer takes it.
`timescale 1ns / 1ps
module gpr_out_stage #(
    parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    output logic                           can_load,
    input  logic [gpr_pkg::BUS_WIDTH-1:0]  res_read_data,
    input  logic [PIN_COUNT-1:0]           res_drive_levels,
    input  logic [PIN_COUNT-1:0]           res_drive_enable,
    input  logic [PIN_COUNT-1:0]           res_pull_up,
    input  logic [PIN_COUNT-1:0]           res_pull_down,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gpr_pkg::BUS_WIDTH-1:0]  m_read_data,
    output logic [PIN_COUNT-1:0]           m_drive_levels,
    output logic [PIN_COUNT-1:0]           m_drive_enable,
    output logic [PIN_COUNT-1:0]           m_pull_up_mask,
    output logic [PIN_COUNT-1:0]           m_pull_down_mask
);
    import gpr_pkg::*;

    logic                  valid_reg;
    logic [BUS_WIDTH-1:0]  rdata_reg;
    logic [PIN_COUNT-1:0]  levels_reg, enable_reg, up_reg, down_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg  <= res_read_data;
            levels_reg <= res_drive_levels;
            enable_reg <= res_drive_enable;
            up_reg     <= res_pull_up;
            down_reg   <= res_pull_down;
        end
    end

    assign m_valid          = valid_reg;
    assign m_read_data      = rdata_reg;
    assign m_drive_levels   = levels_reg;
    assign m_drive_enable   = enable_reg;
    assign m_pull_up_mask   = up_reg;
    assign m_pull_down_mask = down_reg;

endmodule

@@ src/gpio_pin_register_block.sv @@
// Top level of the GPIO register block: input register, register core, result register.
// An access passes through the input register and then the result register. Throughput: one
// access per cycle while m_ready is high; the core decodes and updates state in one pass.
// A stalled result register holds the core back; the input side then takes at most one more
// transfer into the input register. Reset (aresetn low, synchronous): all pins input, latch,
// pulls and pull control cleared, legacy pull scheme selected, both pipeline registers empty.
`timescale 1ns / 1ps
module gpio_pin_register_block #(
    parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [gpr_pkg::OFS_WIDTH-1:0]  s_reg_offset,
    input  logic [gpr_pkg::BUS_WIDTH-1:0]  s_write_data,
    input  logic [PIN_COUNT-1:0]           s_pad_levels,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gpr_pkg::BUS_WIDTH-1:0]  m_read_data,
    output logic [PIN_COUNT-1:0]           m_drive_levels,
    output logic [PIN_COUNT-1:0]           m_drive_enable,
    output logic [PIN_COUNT-1:0]           m_pull_up_mask,
    output logic [PIN_COUNT-1:0]           m_pull_down_mask
);
    import gpr_pkg::*;

    logic                  req_valid, req_type;
    logic [OFS_WIDTH-1:0]  req_offset;
    logic [BUS_WIDTH-1:0]  req_data;
    logic [PIN_COUNT-1:0]  req_pads;
    logic                  can_load, advance;
    logic [BUS_WIDTH-1:0]  res_read_data;
    logic [PIN_COUNT-1:0]  res_drive_levels, res_drive_enable, res_pull_up, res_pull_down;

    // one transfer moves from the input register through the core into the result register
    assign advance = req_valid && can_load;

    gpr_in_stage #(.PIN_COUNT(PIN_COUNT)) u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .s_pad_levels (s_pad_levels),
        .advance      (advance),
        .req_valid    (req_valid),
        .req_type     (req_type),
        .req_offset   (req_offset),
        .req_data     (req_data),
        .req_pads     (req_pads)
    );

    gpr_core #(.PIN_COUNT(PIN_COUNT)) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .advance          (advance),
        .req_type         (req_type),
        .req_offset       (req_offset),
        .req_data         (req_data),
        .req_pads         (req_pads),
        .res_read_data    (res_read_data),
        .res_drive_levels (res_drive_levels),
        .res_drive_enable (res_drive_enable),
        .res_pull_up      (res_pull_up),
        .res_pull_down    (res_pull_down)
    );

    gpr_out_stage #(.PIN_COUNT(PIN_COUNT)) u_out_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .can_load         (can_load),
        .res_read_data    (res_read_data),
        .res_drive_levels (res_drive_levels),
        .res_drive_enable (res_drive_enable),
        .res_pull_up      (res_pull_up),
        .res_pull_down    (res_pull_down),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_drive_levels   (m_drive_levels),
        .m_drive_enable   (m_drive_enable),
        .m_pull_up_mask   (m_pull_up_mask),
        .m_pull_down_mask (m_pull_down_mask)
    );

endmodule

@@ src/gpr_checker.sv @@
// Port-level checks for the GPIO register block, bound to the top level.
`timescale 1ns / 1ps
module gpr_checker #(
    parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic                           cfg_wr_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_req_type,
    input logic [gpr_pkg::OFS_WIDTH-1:0]  s_reg_offset,
    input logic [gpr_pkg::BUS_WIDTH-1:0]  s_write_data,
    input logic [PIN_COUNT-1:0]           s_pad_levels,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [gpr_pkg::BUS_WIDTH-1:0]  m_read_data,
    input logic [PIN_COUNT-1:0]           m_drive_levels,
    input logic [PIN_COUNT-1:0]           m_drive_enable,
    input logic [PIN_COUNT-1:0]           m_pull_up_mask,
    input logic [PIN_COUNT-1:0]           m_pull_down_mask
);
    import gpr_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a pin never has both pulls enabled
    a_pull_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pull_up_mask & m_pull_down_mask) == '0))
        else $error("pull-up and pull-down both enabled");

    // with the result register empty the input side must take a transfer
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register empty");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) &&
        $stable(m_drive_levels) && $stable(m_drive_enable) &&
        $stable(m_pull_up_mask) && $stable(m_pull_down_mask))
        else $error("stalled result changed");

endmodule

bind gpio_pin_register_block gpr_checker #(.PIN_COUNT(PIN_COUNT)) u_gpr_checker (.*);
